FILE: hdl/alidf_pkg.sv
// ----------------------------------------------------------------------------
// alidf_pkg
// Shared types and constants of the array list block.
// ----------------------------------------------------------------------------
package alidf_pkg;

  localparam int unsigned DepthDefault = 64;

  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned PosW      = 6;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned LengthW   = 7;
  localparam int unsigned CapW      = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_FIND   = 2'd3
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

endpackage

FILE: hdl/alidf_if.sv
// ----------------------------------------------------------------------------
// alidf interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface alidf_req_if
  import alidf_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [ReqTypeW-1:0]      req_type;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface alidf_rsp_if
  import alidf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    found_position;
  logic               found;
  logic [LengthW-1:0] length;
  logic               is_empty;

  modport source (output valid, status, found_position, found, length, is_empty,
                  input ready);
  modport sink   (input valid, status, found_position, found, length, is_empty,
                  output ready);
endinterface

interface alidf_cfg_if
  import alidf_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: hdl/array_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_find
// Ordered list of 32-bit words in a single-port-write memory, with append,
// insert, delete and find run by a small sequencer.
// ----------------------------------------------------------------------------
// The block holds one item at a time: req_i is ready only while idle, and
// the response stays on rsp_o until taken. Append and every refused request
// go straight to the response. Insert at position p moves each entry from the
// end down to p one place back, delete at p moves each entry after p one place
// forward, and find compares entries from position 0 until a hit or the end.
// Once the response is taken the block returns to idle and req_i is ready
// again. The entry memory has a registered read: each moved entry is read and
// then written, and each compared entry is read and then compared.
// Capacity writes are taken at any time and should be issued while idle.
module array_list_insert_delete_find
  import alidf_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alidf_cfg_if.sink   cfg_i,
  alidf_req_if.sink   req_i,
  alidf_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CapW) ? CW : CapW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOP = 4'b0010,
    S_MOVE = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CapW-1:0]   cap_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  req_type_e         req_q, req_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] val_q, val_d;
  status_e           status_q, status_d;
  logic              found_q, found_d;

  // entry memory
  logic [ValueW-1:0] mem [DEPTH];
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [ValueW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity;
    end
  end

  logic          full;
  logic [XW-1:0] count_x, pos_in_x, pos_x;
  logic [CW-1:0] idx_m1, idx_p1;

  assign count_x  = XW'(count_q);
  assign pos_in_x = XW'(req_i.position);
  assign pos_x    = XW'(pos_q);
  assign full     = (count_x >= XW'(cap_q)) || (count_q >= CW'(DEPTH));
  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    req_d    = req_q;
    pos_d    = pos_q;
    val_d    = val_q;
    status_d = status_q;
    found_d  = found_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = count_q[AW-1:0];
    raddr    = idx_q[AW-1:0];
    wdata    = req_i.value;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d    = req_type_e'(req_i.req_type);
          pos_d    = req_i.position;
          val_d    = req_i.value;
          status_d = ST_OK;
          found_d  = 1'b0;
          state_d  = S_OUT;
          unique case (req_type_e'(req_i.req_type))
            REQ_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            REQ_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (pos_in_x > count_x) begin
                status_d = ST_BADPOS;
              end else begin
                idx_d   = count_q;
                state_d = S_LOOP;
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_in_x >= count_x) begin
                status_d = ST_BADPOS;
              end else begin
                idx_d   = CW'(req_i.position);
                state_d = S_LOOP;
              end
            end
            REQ_FIND: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_LOOP;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_LOOP: begin
        unique case (req_q)
          REQ_INSERT: begin
            if (XW'(idx_q) > pos_x) begin
              re      = 1'b1;
              raddr   = idx_m1[AW-1:0];
              state_d = S_MOVE;
            end else begin
              // drop the new word into the opened slot
              we      = 1'b1;
              waddr   = idx_q[AW-1:0];
              wdata   = val_q;
              count_d = count_q + CW'(1);
              state_d = S_OUT;
            end
          end
          REQ_DELETE: begin
            if (idx_p1 < count_q) begin
              re      = 1'b1;
              raddr   = idx_p1[AW-1:0];
              state_d = S_MOVE;
            end else begin
              count_d = count_q - CW'(1);
              state_d = S_OUT;
            end
          end
          REQ_FIND: begin
            if (idx_q < count_q) begin
              re      = 1'b1;
              raddr   = idx_q[AW-1:0];
              state_d = S_MOVE;
            end else begin
              status_d = ST_NOTFOUND;
              state_d  = S_OUT;
            end
          end
          default: state_d = S_OUT;
        endcase
      end

      S_MOVE: begin
        unique case (req_q)
          REQ_INSERT: begin
            we      = 1'b1;
            waddr   = idx_q[AW-1:0];
            wdata   = rdata_q;
            idx_d   = idx_m1;
            state_d = S_LOOP;
          end
          REQ_DELETE: begin
            we      = 1'b1;
            waddr   = idx_q[AW-1:0];
            wdata   = rdata_q;
            idx_d   = idx_p1;
            state_d = S_LOOP;
          end
          REQ_FIND: begin
            if (rdata_q == val_q) begin
              found_d = 1'b1;
              state_d = S_OUT;
            end else begin
              idx_d   = idx_p1;
              state_d = S_LOOP;
            end
          end
          default: state_d = S_OUT;
        endcase
      end

      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    req_q    <= req_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_OUT);
  assign rsp_o.status         = status_q;
  assign rsp_o.found          = found_q;
  assign rsp_o.found_position = found_q ? PosW'(idx_q) : '0;
  assign rsp_o.length         = LengthW'(count_q);
  assign rsp_o.is_empty       = (count_q == '0);

endmodule

FILE: test/array_list_insert_delete_find_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_checker
// Watches the configuration, request and response channels of the array
// list block. It keeps its own copy of the list and the capacity, works out
// the response that each accepted request must produce, and compares every
// accepted response with the oldest one still awaited.
// ----------------------------------------------------------------------------
module array_list_insert_delete_find_checker
  import alidf_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alidf_cfg_if        cfg_i,
  alidf_req_if        req_i,
  alidf_rsp_if        rsp_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] found_position;
    logic            found;
    logic [LengthW-1:0] length;
    logic            is_empty;
  } list_rsp_t;

  logic signed [ValueW-1:0] words_q [DEPTH];
  int                       word_count;
  logic [CapW-1:0]          capacity_q;
  list_rsp_t                awaited_rsp_q [$];

  // Apply one request to the list copy and return the response it gives.
  function automatic list_rsp_t update_list(req_type_e op, logic [PosW-1:0] pos,
                                            logic signed [ValueW-1:0] val);
    list_rsp_t rsp;
    int        limit;
    int        p;
    rsp        = '0;
    rsp.status = ST_OK;
    limit      = (int'(capacity_q) > int'(DEPTH)) ? int'(DEPTH) : int'(capacity_q);
    p          = int'(pos);
    case (op)
      REQ_APPEND: begin
        if (word_count >= limit) begin
          rsp.status = ST_FULL;
        end else begin
          words_q[word_count] = val;
          word_count++;
        end
      end
      REQ_INSERT: begin
        // full test wins over the position test
        if (word_count >= limit) begin
          rsp.status = ST_FULL;
        end else if (p > word_count) begin
          rsp.status = ST_BADPOS;
        end else begin
          for (int i = word_count; i > p; i--) words_q[i] = words_q[i-1];
          words_q[p] = val;
          word_count++;
        end
      end
      REQ_DELETE: begin
        if (word_count == 0) begin
          rsp.status = ST_EMPTY;
        end else if (p >= word_count) begin
          rsp.status = ST_BADPOS;
        end else begin
          for (int i = p; i + 1 < word_count; i++) words_q[i] = words_q[i+1];
          word_count--;
        end
      end
      default: begin
        if (word_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.status = ST_NOTFOUND;
          for (int i = 0; i < word_count; i++) begin
            if (words_q[i] == val) begin
              rsp.status         = ST_OK;
              rsp.found_position = i[PosW-1:0];
              rsp.found          = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    rsp.length   = word_count[LengthW-1:0];
    rsp.is_empty = (word_count == 0);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t got;
    list_rsp_t want;
    if (!rst_ni) begin
      word_count    = 0;
      capacity_q    = CapReset;
      awaited_rsp_q.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) capacity_q = cfg_i.capacity;

      // compare before pushing: a response never belongs to the item taken
      // at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        got.status         = status_e'(rsp_i.status);
        got.found_position = rsp_i.found_position;
        got.found          = rsp_i.found;
        got.length         = rsp_i.length;
        got.is_empty       = rsp_i.is_empty;
        if (awaited_rsp_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MaxReports)
            $display("%0t: response with no request waiting: status=%0d fpos=%0d found=%0b len=%0d empty=%0b",
                     $time, got.status, got.found_position, got.found, got.length,
                     got.is_empty);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= MaxReports)
              $display("%0t: expected status=%0d fpos=%0d found=%0b len=%0d empty=%0b, got status=%0d fpos=%0d found=%0b len=%0d empty=%0b",
                       $time, want.status, want.found_position, want.found, want.length,
                       want.is_empty, got.status, got.found_position, got.found,
                       got.length, got.is_empty);
          end
        end
      end

      if (req_i.valid && req_i.ready)
        awaited_rsp_q.push_back(update_list(req_type_e'(req_i.req_type), req_i.position,
                                            req_i.value));
      outstanding_o = awaited_rsp_q.size();
    end
  end

endmodule

FILE: test/array_list_insert_delete_find_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_tb
// Drives the array list block with a directed sequence over every request
// kind and corner case, then with random phases at several capacities, with
// random stalls on both sides and one long response hold-off. A checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module array_list_insert_delete_find_tb;
  import alidf_pkg::*;

  localparam int unsigned Depth         = DepthDefault;
  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 140;

  logic clk;
  logic rst_n;

  alidf_cfg_if cfg_if ();
  alidf_req_if req_if ();
  alidf_rsp_if rsp_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent;
  int unsigned results_taken;
  int unsigned cycle_count;
  bit          gaps_on;
  bit          hold_off_pending;

  array_list_insert_delete_find #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  array_list_insert_delete_find_checker #(
    .DEPTH(Depth)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_if),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      results_taken <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      results_taken <= results_taken + 1;
    end
  end

  // Response side: random stall bursts, plus one long hold-off on request.
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_item(req_type_e op, logic [PosW-1:0] pos,
                           logic signed [ValueW-1:0] val);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    while (results_taken != items_sent) @(posedge clk);
  endtask

  // Only while idle: drain first, then write.
  task automatic write_capacity(logic [CapW-1:0] cap);
    wait_all_results();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly short positions so inserts and deletes land inside the list.
  function automatic logic [PosW-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return PosW'($urandom_range(0, 7));
    if (roll < 8) return PosW'($urandom_range(0, 31));
    return PosW'($urandom_range(0, 63));
  endfunction

  // A small pool of words makes finds hit; the rest is fully random.
  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] pool [8];
    pool = '{32'sd0, -32'sd1, 32'sd1, 32'sd7, 32'sd100, -32'sd100,
             32'sh8000_0000, 32'sh7FFF_FFFF};
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_random_items(int unsigned n, int unsigned pct_append,
                                   int unsigned pct_insert, int unsigned pct_delete);
    int unsigned roll;
    req_type_e   op;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_append) op = REQ_APPEND;
      else if (roll < pct_append + pct_insert) op = REQ_INSERT;
      else if (roll < pct_append + pct_insert + pct_delete) op = REQ_DELETE;
      else op = REQ_FIND;
      send_item(op, pick_position(), pick_value());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_APPEND;
    req_if.position  = '0;
    req_if.value     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.capacity  = CapReset;
    cycle_count      = 0;
    items_sent       = 0;
    gaps_on          = 1'b1;
    hold_off_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad insert position, extremes, insert at the end
    send_item(REQ_FIND,   6'd0,  32'sd0);
    send_item(REQ_DELETE, 6'd0,  32'sd0);
    send_item(REQ_INSERT, 6'd1,  32'sd9);
    send_item(REQ_INSERT, 6'd0,  32'sh8000_0000);
    send_item(REQ_APPEND, 6'd0,  32'sh7FFF_FFFF);
    send_item(REQ_APPEND, 6'd63, -32'sd1);
    send_item(REQ_INSERT, 6'd3,  32'sd0);
    send_item(REQ_INSERT, 6'd1,  32'sd5);
    send_item(REQ_FIND,   6'd0,  -32'sd1);
    send_item(REQ_FIND,   6'd0,  32'sd12345);
    send_item(REQ_DELETE, 6'd5,  32'sd0);
    send_item(REQ_DELETE, 6'd63, -32'sd1);
    send_item(REQ_DELETE, 6'd4,  32'sd0);
    send_item(REQ_DELETE, 6'd0,  32'sd0);
    send_item(REQ_FIND,   6'd0,  32'sh8000_0000);
    // full list: the full test wins over a bad position
    write_capacity(7'd3);
    send_item(REQ_APPEND, 6'd0,  32'sd1);
    send_item(REQ_INSERT, 6'd63, 32'sd1);
    // zero capacity refuses every append and insert
    write_capacity(7'd0);
    send_item(REQ_APPEND, 6'd0,  32'sd2);
    send_item(REQ_INSERT, 6'd0,  32'sd2);
    send_item(REQ_FIND,   6'd0,  32'sh7FFF_FFFF);
    // capacity above the store size is clipped
    write_capacity(7'd127);
    send_item(REQ_APPEND, 6'd0,  32'sd42);
    send_item(REQ_INSERT, 6'd0,  -32'sd7);
    // capacity lowered below the length keeps the entries
    write_capacity(7'd1);
    send_item(REQ_APPEND, 6'd0,  32'sd3);
    send_item(REQ_DELETE, 6'd0,  32'sd0);
    send_item(REQ_FIND,   6'd0,  32'sd42);

    // grow to the full store, pause once for every response in between
    write_capacity(7'd64);
    send_random_items(100, 30, 30, 15);
    wait_all_results();
    send_random_items(100, 30, 30, 15);

    // shrink under a small capacity down to empty
    write_capacity(7'd10);
    send_random_items(120, 15, 15, 45);

    // hold off responses while requests keep coming
    write_capacity(7'd127);
    send_random_items(40, 30, 25, 20);
    hold_off_pending = 1'b1;
    send_random_items(110, 30, 25, 20);

    write_capacity(7'd1);
    send_random_items(60, 25, 25, 25);

    // last part without stalls on either side
    write_capacity(7'd64);
    gaps_on = 1'b0;
    send_random_items(120, 30, 25, 20);

    wait_all_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/alidf_pkg.sv
hdl/alidf_if.sv
hdl/array_list_insert_delete_find.sv
test/array_list_insert_delete_find_checker.sv
test/array_list_insert_delete_find_tb.sv
